// ===== src/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared widths, codes, reset values and state type for the tour evaluator
// and swap mutator.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // item field widths
    localparam int REQ_TYPE_W = 3;
    localparam int TOUR_IN_W  = 5;
    localparam int POS_IN_W   = 4;
    localparam int VAL_W      = 8;
    localparam int DRAW_W     = 16;
    localparam int GENE_W     = 4;
    localparam int LEN_W      = 12;
    localparam int IDX_OUT_W  = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POP_CNT_W  = 6;
    localparam int CITY_CNT_W = 5;

    localparam logic [POP_CNT_W-1:0]  POP_COUNT_RST  = 6'd20;
    localparam logic [CITY_CNT_W-1:0] CITY_COUNT_RST = 5'd15;
    // 0.4 of 65536
    localparam logic [DRAW_W-1:0]     MUT_THRESH_RST = 16'd26214;

    // default sizes
    localparam int MAX_TOURS_DEF  = 32;
    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_BITS_DEF  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POP_COUNT  = 2'd0,
        CFG_CITY_COUNT = 2'd1,
        CFG_MUT_THRESH = 2'd2
    } t_cfg_idx;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_WR_DIST = 3'd0,
        REQ_WR_GENE = 3'd1,
        REQ_MUTATE  = 3'd2,
        REQ_EVAL    = 3'd3,
        REQ_RD_BEST = 3'd4
    } t_req_code;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUT_RDB,
        ST_MUT_WRA,
        ST_MUT_WRB,
        ST_EVAL,
        ST_DRAIN,
        ST_COPY,
        ST_RESP
    } t_state;

endpackage

// ===== src/tsp_req_if.sv =====
// ----------------------------------------------------------------------------
// tsp_req_if
// Request channel: valid/ready handshake with the request item fields.
// ----------------------------------------------------------------------------
interface tsp_req_if import tsp_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [TOUR_IN_W-1:0]  row_or_tour;
    logic [POS_IN_W-1:0]   col_or_pos;
    logic [VAL_W-1:0]      write_value;
    logic [DRAW_W-1:0]     rand_draw;
    logic [POS_IN_W-1:0]   swap_pos_a;
    logic [POS_IN_W-1:0]   swap_pos_b;

    modport source (
        output valid, req_type, row_or_tour, col_or_pos, write_value,
               rand_draw, swap_pos_a, swap_pos_b,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_or_tour, col_or_pos, write_value,
               rand_draw, swap_pos_a, swap_pos_b,
        output ready
    );

endinterface

// ===== src/tsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tsp_rsp_if
// Result channel: valid/ready handshake with the result item fields.
// ----------------------------------------------------------------------------
interface tsp_rsp_if import tsp_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [LEN_W-1:0]     gen_best_len;
    logic [IDX_OUT_W-1:0] gen_best_index;
    logic [LEN_W-1:0]     best_len;
    logic                 improved;
    logic                 mutated;
    logic [GENE_W-1:0]    best_gene;

    modport source (
        output valid, gen_best_len, gen_best_index, best_len, improved,
               mutated, best_gene,
        input  ready
    );

    modport sink (
        input  valid, gen_best_len, gen_best_index, best_len, improved,
               mutated, best_gene,
        output ready
    );

endinterface

// ===== src/tsp_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsp_ram import tsp_pkg::*; #(
    parameter int WIDTH = GENE_W,
    parameter int DEPTH = MAX_TOURS_DEF * MAX_CITIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsp_ctrl
// Item sequencer: loads, swap mutation, tour length pipeline, best tour
// store and result register.
// ----------------------------------------------------------------------------
module tsp_ctrl import tsp_pkg::*; #(
    parameter int MAX_TOURS  = MAX_TOURS_DEF,
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    tsp_req_if.sink                                   i_req,
    tsp_rsp_if.source                                 o_rsp,
    input  logic [$clog2(MAX_CITIES+1)-1:0]           i_n_cities,
    input  logic [$clog2(MAX_TOURS)-1:0]              i_last_tour,
    input  logic [DRAW_W-1:0]                         i_mut_thresh,
    output logic                                      o_pop_we,
    output logic [$clog2(MAX_TOURS*MAX_CITIES)-1:0]   o_pop_waddr,
    output logic [GENE_W-1:0]                         o_pop_wdata,
    output logic [$clog2(MAX_TOURS*MAX_CITIES)-1:0]   o_pop_raddr,
    input  logic [GENE_W-1:0]                         i_pop_rdata,
    output logic                                      o_dist_we,
    output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]  o_dist_waddr,
    output logic [DIST_BITS-1:0]                      o_dist_wdata,
    output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]  o_dist_raddr,
    input  logic [DIST_BITS-1:0]                      i_dist_rdata
);

    localparam int CITY_W    = $clog2(MAX_CITIES);
    localparam int TOUR_W    = $clog2(MAX_TOURS);
    localparam int POS_CNT_W = $clog2(MAX_CITIES + 1);
    localparam int POP_AW    = $clog2(MAX_TOURS * MAX_CITIES);
    localparam int DIST_AW   = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int SUM_W     = ((DIST_BITS > LEN_W) ? DIST_BITS : LEN_W) + 1;

    function automatic logic [POP_AW-1:0] pop_addr(input logic [TOUR_W-1:0] t,
                                                   input logic [CITY_W-1:0] p);
        pop_addr = POP_AW'(t) * POP_AW'(MAX_CITIES) + POP_AW'(p);
    endfunction

    function automatic logic [DIST_AW-1:0] dist_addr(input logic [GENE_W-1:0] a,
                                                     input logic [GENE_W-1:0] b);
        dist_addr = DIST_AW'(a) * DIST_AW'(MAX_CITIES) + DIST_AW'(b);
    endfunction

    function automatic logic city_ok(input logic [GENE_W-1:0] g);
        city_ok = 32'(g) < 32'(MAX_CITIES);
    endfunction

    t_state r_state, n_state;

    // captured item
    logic [REQ_TYPE_W-1:0] r_req_type;
    logic [TOUR_IN_W-1:0]  r_row;
    logic [POS_IN_W-1:0]   r_col;
    logic [VAL_W-1:0]      r_val;
    logic [DRAW_W-1:0]     r_draw;
    logic [POS_IN_W-1:0]   r_pa;
    logic [POS_IN_W-1:0]   r_pb;

    // sequencing
    logic [POS_CNT_W-1:0]  r_pos;
    logic [TOUR_W-1:0]     r_tour;
    logic [GENE_W-1:0]     r_ga;

    // length pipeline
    logic                  r_s1_valid, r_s1_first, r_s1_second, r_s1_last;
    logic [TOUR_W-1:0]     r_s1_tour;
    logic [GENE_W-1:0]     r_prev;
    logic                  r_s2_valid, r_s2_start, r_s2_last, r_s2_zero;
    logic [TOUR_W-1:0]     r_s2_tour;
    logic [LEN_W-1:0]      r_acc;
    logic                  r_s3_valid;
    logic [TOUR_W-1:0]     r_s3_tour;

    // generation and overall best
    logic [LEN_W-1:0]      r_gb_len;
    logic [TOUR_W-1:0]     r_gb_idx;
    logic [LEN_W-1:0]      r_best_len;
    logic                  r_best_valid;

    // best tour store
    logic [GENE_W-1:0]     r_bt_mem [MAX_CITIES];
    logic [MAX_CITIES-1:0] r_bt_vld;
    logic                  r_c1_valid;
    logic [CITY_W-1:0]     r_c1_pos;
    logic [GENE_W-1:0]     r_bt_rd;
    logic                  r_bt_ok;

    // flags and result register
    logic                  r_improved, r_mutated;
    logic                  r_out_valid;
    logic [LEN_W-1:0]      r_o_gb_len;
    logic [IDX_OUT_W-1:0]  r_o_gb_idx;
    logic [LEN_W-1:0]      r_o_best_len;
    logic                  r_o_improved, r_o_mutated;
    logic [GENE_W-1:0]     r_o_gene;

    logic                  accept, out_free, pipe_busy, improve, mut_ok;
    logic                  dist_ok, gene_wr_ok, at_end;
    logic [CITY_W-1:0]     eval_pos;
    logic [POP_AW-1:0]     addr_a, addr_b;
    logic [SUM_W-1:0]      sum;
    logic [LEN_W-1:0]      acc_in, acc_next;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign pipe_busy = r_s1_valid || r_s2_valid || r_s3_valid;
    assign improve   = !r_best_valid || (r_gb_len < r_best_len);
    assign at_end    = r_pos == i_n_cities;
    assign eval_pos  = at_end ? '0 : r_pos[CITY_W-1:0];

    assign mut_ok = (32'(r_row) < 32'(MAX_TOURS)) &&
                    (32'(r_pa) < 32'(i_n_cities)) &&
                    (32'(r_pb) < 32'(i_n_cities)) &&
                    (r_draw <= i_mut_thresh);
    assign dist_ok    = (32'(r_row) < 32'(MAX_CITIES)) && (32'(r_col) < 32'(MAX_CITIES));
    assign gene_wr_ok = (32'(r_row) < 32'(MAX_TOURS)) && (32'(r_col) < 32'(MAX_CITIES));
    assign addr_a     = pop_addr(TOUR_W'(r_row), CITY_W'(r_pa));
    assign addr_b     = pop_addr(TOUR_W'(r_row), CITY_W'(r_pb));

    // distance lookup for the pair arriving from the population read
    assign o_dist_raddr = dist_addr(r_prev, i_pop_rdata);

    // saturating accumulate
    assign acc_in   = r_s2_start ? '0 : r_acc;
    assign sum      = SUM_W'(acc_in) + SUM_W'(r_s2_zero ? '0 : i_dist_rdata);
    assign acc_next = (sum > SUM_W'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_req.ready  = 1'b0;
        o_pop_we     = 1'b0;
        o_pop_waddr  = '0;
        o_pop_wdata  = '0;
        o_pop_raddr  = '0;
        o_dist_we    = 1'b0;
        o_dist_waddr = dist_addr(GENE_W'(r_row), GENE_W'(r_col));
        o_dist_wdata = DIST_BITS'(r_val);
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RESP;
                case (r_req_type)
                    REQ_WR_DIST: begin
                        o_dist_we = dist_ok;
                    end
                    REQ_WR_GENE: begin
                        o_pop_we    = gene_wr_ok;
                        o_pop_waddr = pop_addr(TOUR_W'(r_row), CITY_W'(r_col));
                        o_pop_wdata = r_val[GENE_W-1:0];
                    end
                    REQ_MUTATE: begin
                        o_pop_raddr = addr_a;
                        if (mut_ok) n_state = ST_MUT_RDB;
                    end
                    REQ_EVAL: begin
                        n_state = ST_EVAL;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_MUT_RDB: begin
                o_pop_raddr = addr_b;
                n_state     = ST_MUT_WRA;
            end
            ST_MUT_WRA: begin
                o_pop_we    = 1'b1;
                o_pop_waddr = addr_a;
                o_pop_wdata = i_pop_rdata;
                n_state     = ST_MUT_WRB;
            end
            ST_MUT_WRB: begin
                o_pop_we    = 1'b1;
                o_pop_waddr = addr_b;
                o_pop_wdata = r_ga;
                n_state     = ST_RESP;
            end
            ST_EVAL: begin
                o_pop_raddr = pop_addr(r_tour, eval_pos);
                if (at_end && (r_tour == i_last_tour)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!pipe_busy) n_state = improve ? ST_COPY : ST_RESP;
            end
            ST_COPY: begin
                o_pop_raddr = pop_addr(r_gb_idx, r_pos[CITY_W-1:0]);
                if (at_end && !r_c1_valid) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    i_req.ready = 1'b1;
                    n_state     = i_req.valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and visible best values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_c1_valid   <= 1'b0;
            r_gb_len     <= '0;
            r_gb_idx     <= '0;
            r_best_len   <= '0;
            r_best_valid <= 1'b0;
            r_bt_vld     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_s1_valid <= r_state == ST_EVAL;
            r_s2_valid <= r_s1_valid && !r_s1_first;
            r_s3_valid <= r_s2_valid && r_s2_last;
            r_c1_valid <= (r_state == ST_COPY) && !at_end;
            // r_acc holds the finished tour here; the next tour's first sum has not yet overwritten it
            if (r_s3_valid && ((r_s3_tour == '0) || (r_acc < r_gb_len))) begin
                r_gb_len <= r_acc;
                r_gb_idx <= r_s3_tour;
            end
            if ((r_state == ST_DRAIN) && !pipe_busy && improve) begin
                r_best_valid <= 1'b1;
                r_best_len   <= r_gb_len;
            end
            if (r_c1_valid) r_bt_vld[r_c1_pos] <= 1'b1;
            if ((r_state == ST_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_row      <= i_req.row_or_tour;
            r_col      <= i_req.col_or_pos;
            r_val      <= i_req.write_value;
            r_draw     <= i_req.rand_draw;
            r_pa       <= i_req.swap_pos_a;
            r_pb       <= i_req.swap_pos_b;
        end

        case (r_state)
            ST_EXEC: begin
                r_improved <= 1'b0;
                r_mutated  <= 1'b0;
                r_pos      <= '0;
                r_tour     <= '0;
                r_bt_rd    <= r_bt_mem[CITY_W'(r_col)];
                r_bt_ok    <= (32'(r_col) < 32'(MAX_CITIES)) && r_bt_vld[CITY_W'(r_col)];
            end
            ST_MUT_RDB: begin
                r_ga <= i_pop_rdata;
            end
            ST_MUT_WRB: begin
                r_mutated <= 1'b1;
            end
            ST_EVAL: begin
                if (at_end) begin
                    r_pos  <= '0;
                    r_tour <= r_tour + 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy && improve) r_improved <= 1'b1;
                r_pos <= '0;
            end
            ST_COPY: begin
                if (!at_end) begin
                    r_pos    <= r_pos + 1'b1;
                    r_c1_pos <= r_pos[CITY_W-1:0];
                end
            end
            default: begin
            end
        endcase

        // stage 1 tags for the population read issued this cycle
        r_s1_first  <= r_pos == '0;
        r_s1_second <= r_pos == POS_CNT_W'(1);
        r_s1_last   <= at_end;
        r_s1_tour   <= r_tour;

        // stage 1: gene arrives, pair goes to the distance read
        if (r_s1_valid) begin
            r_prev     <= i_pop_rdata;
            r_s2_start <= r_s1_second;
            r_s2_last  <= r_s1_last;
            r_s2_zero  <= !(city_ok(r_prev) && city_ok(i_pop_rdata));
            r_s2_tour  <= r_s1_tour;
        end

        // stage 2: distance arrives
        if (r_s2_valid) begin
            r_acc     <= acc_next;
            r_s3_tour <= r_s2_tour;
        end

        if (r_c1_valid) r_bt_mem[r_c1_pos] <= i_pop_rdata;

        if ((r_state == ST_RESP) && out_free) begin
            r_o_gb_len   <= r_gb_len;
            r_o_gb_idx   <= IDX_OUT_W'(r_gb_idx);
            r_o_best_len <= r_best_len;
            r_o_improved <= r_improved;
            r_o_mutated  <= r_mutated;
            r_o_gene     <= ((r_req_type == REQ_RD_BEST) && r_bt_ok) ? r_bt_rd : '0;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.gen_best_len   = r_o_gb_len;
    assign o_rsp.gen_best_index = r_o_gb_idx;
    assign o_rsp.best_len       = r_o_best_len;
    assign o_rsp.improved       = r_o_improved;
    assign o_rsp.mutated        = r_o_mutated;
    assign o_rsp.best_gene      = r_o_gene;

endmodule

// ===== src/tsp_tour_evaluator_mutator.sv =====
// ----------------------------------------------------------------------------
// tsp_tour_evaluator_mutator
// Tour store and evaluator for a genetic travelling-salesman search.
// ----------------------------------------------------------------------------
// Usage
//   i_req carries one request item (valid/ready); o_rsp returns exactly one
//   result item per request, in order. Config registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Operation
//   a swap mutate makes two reads and two writes on the gene RAM. Evaluate
//   reads one gene per cycle through the single read port of the gene RAM,
//   rereading each tour's first gene to close the cycle; when the best tour
//   is replaced, it is then copied into the best tour store.
// Reset
//   synchronous, active low. Config returns to 20 tours, 15 cities and a
//   threshold of 0.4; best tour reads as zero, best length zero. Distance
//   and gene RAMs are not cleared and must be loaded before use.
// Back-pressure
//   a finished result sits in the output register; one more item is taken
//   and worked, then held until that register is free or being emptied,
//   and the request side stalls meanwhile.
// ----------------------------------------------------------------------------
module tsp_tour_evaluator_mutator import tsp_pkg::*; #(
    parameter int MAX_TOURS  = MAX_TOURS_DEF,
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsp_req_if.sink               i_req,
    tsp_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TOUR_W    = $clog2(MAX_TOURS);
    localparam int POS_CNT_W = $clog2(MAX_CITIES + 1);
    localparam int POP_DEPTH = MAX_TOURS * MAX_CITIES;
    localparam int POP_AW    = $clog2(POP_DEPTH);
    localparam int DIST_DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int DIST_AW   = $clog2(DIST_DEPTH);

    // configuration registers
    logic [POP_CNT_W-1:0]  r_pop_count;
    logic [CITY_CNT_W-1:0] r_city_count;
    logic [DRAW_W-1:0]     r_mut_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count  <= POP_COUNT_RST;
            r_city_count <= CITY_COUNT_RST;
            r_mut_thresh <= MUT_THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POP_COUNT:  r_pop_count  <= i_cfg_data[POP_CNT_W-1:0];
                CFG_CITY_COUNT: r_city_count <= i_cfg_data[CITY_CNT_W-1:0];
                CFG_MUT_THRESH: r_mut_thresh <= i_cfg_data[DRAW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp register values into the sizes the stores hold
    logic [POS_CNT_W-1:0] n_cities;
    logic [TOUR_W-1:0]    last_tour;

    always_comb begin
        if (32'(r_city_count) < 32'd2) begin
            n_cities = POS_CNT_W'(2);
        end else if (32'(r_city_count) > 32'(MAX_CITIES)) begin
            n_cities = POS_CNT_W'(MAX_CITIES);
        end else begin
            n_cities = POS_CNT_W'(r_city_count);
        end

        if (r_pop_count == '0) begin
            last_tour = '0;
        end else if (32'(r_pop_count) > 32'(MAX_TOURS)) begin
            last_tour = TOUR_W'(MAX_TOURS - 1);
        end else begin
            last_tour = TOUR_W'(r_pop_count - 1'b1);
        end
    end

    // gene and distance RAMs
    logic                 pop_we;
    logic [POP_AW-1:0]    pop_waddr, pop_raddr;
    logic [GENE_W-1:0]    pop_wdata, pop_rdata;
    logic                 dist_we;
    logic [DIST_AW-1:0]   dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0] dist_wdata, dist_rdata;

    tsp_ram #(
        .WIDTH (GENE_W),
        .DEPTH (POP_DEPTH)
    ) u_pop_ram (
        .i_clk   (i_clk),
        .i_we    (pop_we),
        .i_waddr (pop_waddr),
        .i_wdata (pop_wdata),
        .i_raddr (pop_raddr),
        .o_rdata (pop_rdata)
    );

    tsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DIST_DEPTH)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    tsp_ctrl #(
        .MAX_TOURS  (MAX_TOURS),
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_n_cities   (n_cities),
        .i_last_tour  (last_tour),
        .i_mut_thresh (r_mut_thresh),
        .o_pop_we     (pop_we),
        .o_pop_waddr  (pop_waddr),
        .o_pop_wdata  (pop_wdata),
        .o_pop_raddr  (pop_raddr),
        .i_pop_rdata  (pop_rdata),
        .o_dist_we    (dist_we),
        .o_dist_waddr (dist_waddr),
        .o_dist_wdata (dist_wdata),
        .o_dist_raddr (dist_raddr),
        .i_dist_rdata (dist_rdata)
    );

endmodule

// ===== tb/sv/tsp_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsp_result_checker
// Watches the request, result and register ports of the tour evaluator,
// keeps its own copy of the distance table, population and best tour, and
// compares every result item field by field with the predicted one.
// ----------------------------------------------------------------------------
module tsp_result_checker import tsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsp_req_if                    i_req,
    tsp_rsp_if                    i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int TOURS  = MAX_TOURS_DEF;
    localparam int CITIES = MAX_CITIES_DEF;

    typedef struct packed {
        logic [LEN_W-1:0]     gen_len;
        logic [IDX_OUT_W-1:0] gen_index;
        logic [LEN_W-1:0]     best_len;
        logic                 improved;
        logic                 mutated;
        logic [GENE_W-1:0]    best_gene;
    } t_tour_result;

    logic [DIST_BITS_DEF-1:0] dist_mem      [CITIES][CITIES];
    logic [GENE_W-1:0]        gene_mem      [TOURS][CITIES];
    logic [GENE_W-1:0]        best_tour_mem [CITIES];
    logic [LEN_W-1:0]         best_len_q;
    logic                     best_ok;
    logic [LEN_W-1:0]         gen_len_q;
    logic [IDX_OUT_W-1:0]     gen_idx_q;
    logic [POP_CNT_W-1:0]     pop_reg;
    logic [CITY_CNT_W-1:0]    city_reg;
    logic [DRAW_W-1:0]        thr_reg;

    t_tour_result expected_results [$];
    t_tour_result got_res;
    t_tour_result want_res;
    int           mismatch_cnt = 0;
    int           checked_cnt  = 0;

    function automatic int cities_in_use();
        if (city_reg < 2) return 2;
        if (city_reg > CITIES) return CITIES;
        return int'(city_reg);
    endfunction

    // cyclic length of one tour, saturating
    function automatic int tour_length_of(int t, int n);
        int sum;
        int nx;
        sum = 0;
        for (int j = 0; j < n; j++) begin
            nx = (j + 1 == n) ? 0 : j + 1;
            sum += int'(dist_mem[gene_mem[t][j]][gene_mem[t][nx]]);
            if (sum > int'(LEN_MAX)) sum = int'(LEN_MAX);
        end
        return sum;
    endfunction

    function automatic t_tour_result apply_tour_request(
        input logic [REQ_TYPE_W-1:0] kind,
        input logic [TOUR_IN_W-1:0]  row,
        input logic [POS_IN_W-1:0]   col,
        input logic [VAL_W-1:0]      val,
        input logic [DRAW_W-1:0]     draw,
        input logic [POS_IN_W-1:0]   pa,
        input logic [POS_IN_W-1:0]   pb
    );
        t_tour_result     r;
        int               n;
        int               np;
        int               bl;
        int               bi;
        int               len;
        logic [GENE_W-1:0] held;
        r = '0;
        case (kind)
            REQ_WR_DIST: begin
                if (row < CITIES) dist_mem[row[POS_IN_W-1:0]][col] = val;
            end
            REQ_WR_GENE: begin
                if (row < TOURS) gene_mem[row][col] = val[GENE_W-1:0];
            end
            REQ_MUTATE: begin
                n = cities_in_use();
                if (row < TOURS && pa < n && pb < n && draw <= thr_reg) begin
                    held              = gene_mem[row][pa];
                    gene_mem[row][pa] = gene_mem[row][pb];
                    gene_mem[row][pb] = held;
                    r.mutated         = 1'b1;
                end
            end
            REQ_EVAL: begin
                n  = cities_in_use();
                np = (pop_reg == 0) ? 1 : ((pop_reg > TOURS) ? TOURS : int'(pop_reg));
                bl = tour_length_of(0, n);
                bi = 0;
                for (int i = 1; i < np; i++) begin
                    len = tour_length_of(i, n);
                    if (len < bl) begin
                        bl = len;
                        bi = i;
                    end
                end
                gen_len_q = bl[LEN_W-1:0];
                gen_idx_q = bi[IDX_OUT_W-1:0];
                if (!best_ok || bl < int'(best_len_q)) begin
                    for (int j = 0; j < n; j++) best_tour_mem[j] = gene_mem[bi][j];
                    best_len_q = bl[LEN_W-1:0];
                    best_ok    = 1'b1;
                    r.improved = 1'b1;
                end
            end
            REQ_RD_BEST: begin
                r.best_gene = best_tour_mem[col];
            end
            default: ;
        endcase
        r.gen_len   = gen_len_q;
        r.gen_index = gen_idx_q;
        r.best_len  = best_len_q;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    initial begin
        foreach (dist_mem[a, b]) dist_mem[a][b] = '0;
        foreach (gene_mem[a, b]) gene_mem[a][b] = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop_reg    = POP_COUNT_RST;
            city_reg   = CITY_COUNT_RST;
            thr_reg    = MUT_THRESH_RST;
            foreach (best_tour_mem[j]) best_tour_mem[j] = '0;
            best_len_q = '0;
            best_ok    = 1'b0;
            gen_len_q  = '0;
            gen_idx_q  = '0;
            expected_results.delete();
        end else begin
            // results first: one accepted here always belongs to an older item
            if (i_rsp.valid && i_rsp.ready) begin
                got_res.gen_len   = i_rsp.gen_best_len;
                got_res.gen_index = i_rsp.gen_best_index;
                got_res.best_len  = i_rsp.best_len;
                got_res.improved  = i_rsp.improved;
                got_res.mutated   = i_rsp.mutated;
                got_res.best_gene = i_rsp.best_gene;
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    mismatch_cnt++;
                end else begin
                    want_res = expected_results.pop_front();
                    check_field("gen_best_len", 16'(want_res.gen_len),
                                16'(got_res.gen_len));
                    check_field("gen_best_index", 16'(want_res.gen_index),
                                16'(got_res.gen_index));
                    check_field("best_len", 16'(want_res.best_len),
                                16'(got_res.best_len));
                    check_field("improved", 16'(want_res.improved),
                                16'(got_res.improved));
                    check_field("mutated", 16'(want_res.mutated),
                                16'(got_res.mutated));
                    check_field("best_gene", 16'(want_res.best_gene),
                                16'(got_res.best_gene));
                    checked_cnt++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(apply_tour_request(
                    i_req.req_type, i_req.row_or_tour, i_req.col_or_pos,
                    i_req.write_value, i_req.rand_draw, i_req.swap_pos_a,
                    i_req.swap_pos_b));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POP_COUNT:  pop_reg  = i_cfg_data[POP_CNT_W-1:0];
                    CFG_CITY_COUNT: city_reg = i_cfg_data[CITY_CNT_W-1:0];
                    CFG_MUT_THRESH: thr_reg  = i_cfg_data[DRAW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= expected_results.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tour evaluator and swap mutator. Loads the
// whole distance table and population, runs a directed pass over the corner
// cases, then random phases under several register settings and idling
// patterns. Checking is done by tsp_result_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import tsp_pkg::*;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [TOUR_IN_W-1:0]  row;
        logic [POS_IN_W-1:0]   col;
        logic [VAL_W-1:0]      val;
        logic [DRAW_W-1:0]     draw;
        logic [POS_IN_W-1:0]   pa;
        logic [POS_IN_W-1:0]   pb;
    } t_tour_req;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;       // idle gap before a register write
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;     // long result back-pressure
    // worst case is far below this: every item an evaluate of 32 x 16
    // plus the longest stalls would still fit
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int N_PHASES      = 9;
    localparam int TOURS         = MAX_TOURS_DEF;
    localparam int CITIES        = MAX_CITIES_DEF;
    localparam int REQ_CODES     = 1 << REQ_TYPE_W;

    // random phases: register setting, idling and length
    // a threshold of -1 picks a fresh random one
    int ph_pop   [N_PHASES] = '{20, 6, 1, 32, 0, 63, 8, 12, 3};
    int ph_city  [N_PHASES] = '{15, 5, 2, 16, 0, 31, 8, 10, 4};
    int ph_thr   [N_PHASES] = '{26214, -1, 0, 65535, 40000, -1, -1, 32768, -1};
    int ph_tx    [N_PHASES] = '{0, 71, 0, 11, 0, 71, 0, 11, 0};
    int ph_rx    [N_PHASES] = '{0, 0, 71, 11, 0, 0, 71, 11, 0};
    int ph_items [N_PHASES] = '{40, 40, 30, 35, 30, 25, 40, 40, 30};
    bit ph_hold  [N_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 1};
    bit ph_pause [N_PHASES] = '{0, 1, 0, 0, 0, 0, 0, 0, 0};

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsp_req_if req_ch ();
    tsp_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;

    // idling controls; rx side is read by the result-side process
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // what the stimulus currently assumes about the registers
    int cur_city = 15;
    int cur_thr  = 26214;

    int items_sent    = 0;
    int evals_sent    = 0;
    int mutates_sent  = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;

    tsp_tour_evaluator_mutator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tsp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tsp_tour_evaluator_mutator: mismatch");
            $finish;
        end
    end

    // Result side. A bump of hold_trigger starts one long hold-off, counted
    // here; otherwise ready drops at random per the current stall rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic t_tour_req make_req(int kind, int row, int col, int val,
                                           int draw, int pa, int pb);
        t_tour_req r;
        r.kind = kind[REQ_TYPE_W-1:0];
        r.row  = row[TOUR_IN_W-1:0];
        r.col  = col[POS_IN_W-1:0];
        r.val  = val[VAL_W-1:0];
        r.draw = draw[DRAW_W-1:0];
        r.pa   = pa[POS_IN_W-1:0];
        r.pb   = pb[POS_IN_W-1:0];
        return r;
    endfunction

    // Mostly well-formed traffic: loads, mutates on valid positions with
    // draws often right at the threshold, evaluates and reads; the rest is
    // out-of-range rows, positions past the tour end and unused codes.
    function automatic t_tour_req random_req();
        t_tour_req r;
        int        pick;
        int        n;
        int        d;
        r.kind = REQ_TYPE_W'($urandom_range(REQ_CODES - 1));
        r.row  = TOUR_IN_W'($urandom_range(TOURS - 1));
        r.col  = POS_IN_W'($urandom_range(CITIES - 1));
        r.val  = VAL_W'($urandom_range(255));
        r.draw = DRAW_W'($urandom_range(65535));
        r.pa   = POS_IN_W'($urandom_range(CITIES - 1));
        r.pb   = POS_IN_W'($urandom_range(CITIES - 1));
        n      = (cur_city < 2) ? 2 : ((cur_city > CITIES) ? CITIES : cur_city);
        pick   = $urandom_range(99);
        if (pick < 20) begin
            r.kind = REQ_WR_DIST;
            // rows past the table are ignored: keep them to about one in twenty
            if ($urandom_range(9) != 0) r.row[TOUR_IN_W-1] = 1'b0;
        end else if (pick < 38) begin
            r.kind = REQ_WR_GENE;
        end else if (pick < 70) begin
            r.kind = REQ_MUTATE;
            if ($urandom_range(99) < 85) begin
                r.pa = POS_IN_W'($urandom_range(n - 1));
                r.pb = POS_IN_W'($urandom_range(n - 1));
            end
            if ($urandom_range(2) == 0) begin
                d = cur_thr + int'($urandom_range(4)) - 2;
                if (d < 0) d = 0;
                if (d > 65535) d = 65535;
                r.draw = d[DRAW_W-1:0];
            end
        end else if (pick < 80) begin
            r.kind = REQ_EVAL;
        end else if (pick < 94) begin
            r.kind = REQ_RD_BEST;
        end else begin
            r.kind = REQ_TYPE_W'($urandom_range(REQ_CODES - 1, int'(REQ_RD_BEST) + 1));
        end
        return r;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and hold it
    // until it is taken. valid is left high for a back-to-back follower.
    task automatic send_item(input t_tour_req r);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.kind;
        req_ch.row_or_tour <= r.row;
        req_ch.col_or_pos  <= r.col;
        req_ch.write_value <= r.val;
        req_ch.rand_draw   <= r.draw;
        req_ch.swap_pos_a  <= r.pa;
        req_ch.swap_pos_b  <= r.pb;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
        if (r.kind == REQ_EVAL) evals_sent++;
        if (r.kind == REQ_MUTATE) mutates_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all three registers back to back; only called with the block idle
    task automatic write_settings(input int pop, input int city, input int thr);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_POP_COUNT;
        cfg_data <= pop[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_idx  <= CFG_CITY_COUNT;
        cfg_data <= city[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_idx  <= CFG_MUT_THRESH;
        cfg_data <= thr[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_city = city;
        cur_thr  = thr;
        settings_used++;
    endtask

    initial begin
        logic [GENE_W-1:0] perm [CITIES];
        logic [GENE_W-1:0] held;
        int                k;
        int                thr;

        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_RD_BEST;
        req_ch.row_or_tour <= '0;
        req_ch.col_or_pos  <= '0;
        req_ch.write_value <= '0;
        req_ch.rand_draw   <= '0;
        req_ch.swap_pos_a  <= '0;
        req_ch.swap_pos_b  <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_POP_COUNT;
        cfg_data           <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // best tour is zero out of reset; readable before anything is loaded
        send_item(make_req(REQ_RD_BEST, 0, CITIES - 1, 0, 0, 0, 0));

        // Load every distance and every gene so that no later evaluate or
        // swap can touch an entry that was never written. Each tour starts
        // as a shuffled visit of all cities.
        for (int a = 0; a < CITIES; a++) begin
            for (int b = 0; b < CITIES; b++) begin
                send_item(make_req(REQ_WR_DIST, a, b, $urandom_range(255),
                                   $urandom_range(65535), 0, 0));
            end
        end
        for (int t = 0; t < TOURS; t++) begin
            for (int j = 0; j < CITIES; j++) perm[j] = j[GENE_W-1:0];
            for (int j = CITIES - 1; j > 0; j--) begin
                k       = $urandom_range(j);
                held    = perm[j];
                perm[j] = perm[k];
                perm[k] = held;
            end
            for (int j = 0; j < CITIES; j++) begin
                send_item(make_req(REQ_WR_GENE, t, j, perm[j], 0, 0, 0));
            end
        end

        // Directed pass at the reset setting (20 tours, 15 cities, 0.4).
        // First evaluate always takes the best; a repeat with nothing
        // changed must not, as only a strictly shorter tour replaces it.
        send_item(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_RD_BEST, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_RD_BEST, 0, CITIES - 1, 0, 0, 0, 0));
        // draw equal to the threshold swaps, one above does not
        send_item(make_req(REQ_MUTATE, 0, 0, 0, 26214, 0, 14));
        send_item(make_req(REQ_MUTATE, 0, 0, 0, 26215, 0, 14));
        // equal positions still count as a swap
        send_item(make_req(REQ_MUTATE, 5, 0, 0, 0, 3, 3));
        // position past the last city in use: no swap
        send_item(make_req(REQ_MUTATE, 0, 0, 0, 0, 0, CITIES - 1));
        // tour outside the population in use is still swapped
        send_item(make_req(REQ_MUTATE, TOURS - 1, 0, 0, 0, 14, 0));
        // distance row past the table is ignored; corners of the table
        send_item(make_req(REQ_WR_DIST, TOURS - 1, CITIES - 1, 255, 65535, 15, 15));
        send_item(make_req(REQ_WR_DIST, CITIES - 1, CITIES - 1, 255, 0, 0, 0));
        send_item(make_req(REQ_WR_DIST, 0, 0, 0, 0, 0, 0));
        // gene write keeps the low four bits of the value
        send_item(make_req(REQ_WR_GENE, TOURS - 1, CITIES - 1, 255, 0, 0, 0));
        send_item(make_req(REQ_WR_GENE, 0, 0, 0, 0, 0, 0));
        // unused codes leave everything as it is
        for (int c = int'(REQ_RD_BEST) + 1; c < REQ_CODES; c++) begin
            send_item(make_req(c, $urandom_range(31), $urandom_range(15),
                               $urandom_range(255), $urandom_range(65535),
                               $urandom_range(15), $urandom_range(15)));
        end
        send_item(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_RD_BEST, 0, 7, 0, 0, 0, 0));
        wait_idle();

        // Two tours of two cities visiting the same pair in opposite order
        // have equal length: the first must win the tie. Threshold zero
        // swaps only on a draw of zero.
        write_settings(2, 2, 0);
        send_item(make_req(REQ_WR_GENE, 0, 0, 3, 0, 0, 0));
        send_item(make_req(REQ_WR_GENE, 0, 1, 5, 0, 0, 0));
        send_item(make_req(REQ_WR_GENE, 1, 0, 5, 0, 0, 0));
        send_item(make_req(REQ_WR_GENE, 1, 1, 3, 0, 0, 0));
        send_item(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_MUTATE, 1, 0, 0, 0, 0, 1));
        send_item(make_req(REQ_MUTATE, 1, 0, 0, 1, 0, 1));
        send_item(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_RD_BEST, 0, 1, 0, 0, 0, 0));
        wait_idle();

        // Random phases. Sizes stay small for most of the run; the largest
        // and the out-of-range settings get one phase each.
        for (int p = 0; p < N_PHASES; p++) begin
            thr = (ph_thr[p] < 0) ? int'($urandom_range(65535)) : ph_thr[p];
            write_settings(ph_pop[p], ph_city[p], thr);
            tx_idle_pct = ph_tx[p];
            rx_stall_pct <= ph_rx[p];
            for (int i = 0; i < ph_items[p]; i++) begin
                // long result hold-off while the sender keeps offering:
                // output register fills and the request side must stall
                if (ph_hold[p] && i == ph_items[p] / 4) hold_trigger <= hold_trigger + 1;
                // sender drains everything mid-phase, then carries on
                if (ph_pause[p] && i == ph_items[p] / 2) wait_idle();
                send_item(random_req());
            end
            wait_idle();
        end

        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run: %0d items (%0d evaluates, %0d mutates) over %0d register settings",
                 items_sent, evals_sent, mutates_sent, settings_used);
        $display("run: %0d result items compared, %0d field errors", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tsp_tour_evaluator_mutator: match");
        end else begin
            $display("tsp_tour_evaluator_mutator: mismatch");
        end
        $finish;
    end

endmodule
